/* design/tile_average_nearest_color_match_defines.svh */
// Assertion macros for the port-level checker of the tile-average color matcher.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef TILE_AVERAGE_NEAREST_COLOR_MATCH_DEFINES_SVH
`define TILE_AVERAGE_NEAREST_COLOR_MATCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TANC_ASSERT_IMPL(LBL, CLK, RSTN, A, C, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |-> (C)) else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define TANC_ASSERT_NEXT(LBL, CLK, RSTN, A, C, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |=> (C)) else $error(MSG);

`endif

/* design/tanc_pkg.sv */
// Package for the tile-average nearest color matcher: field widths, command codes,
// register indexes and grid constants. Depends on nothing.
package tanc_pkg;

    localparam int TILES_PER_SIDE = 3;
    localparam int CHANNELS       = 3;
    localparam int NTILES         = TILES_PER_SIDE * TILES_PER_SIDE;
    localparam int NENTRIES       = NTILES * CHANNELS;

    localparam int MAX_DIM_DEF = 64;
    localparam int DIM_MIN     = 2;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int COLOR_W = 8;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W   = 18;
    localparam int AVG_W   = 8;
    localparam int TILE_W  = 4;
    localparam int DIST_W  = 10;

    localparam int NO_RECORD = 256 * 3;
    localparam int MAX_DIST  = 255 * 3;

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(36);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(32);

    localparam logic [CMD_W-1:0] CMD_ACCUM    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

endpackage

/* design/tile_average_nearest_color_match.sv */
// Tile-average nearest color matcher. The frame is covered by a 3x3 grid of
// overlapping tiles, each half the frame wide and high. An accumulate transaction
// runs a setup state, then one sum entry per cycle over the 27 entries. A finish
// transaction walks the 27 sums through one shared restoring divider; an entry
// whose average clips at 255 skips the bit-by-bit division. A classify transaction
// runs a setup state, then one tile per cycle through one distance-and-compare
// unit, then a post state that waits until the output register is free.
// The input is stalled for the whole of a transaction; a posted result waits in
// its output register and does not hold up the next input transaction.
// Depends on tanc_pkg and tanc_div.
module tile_average_nearest_color_match import tanc_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [COLOR_W-1:0]   i_red,
    input  logic [COLOR_W-1:0]   i_green,
    input  logic [COLOR_W-1:0]   i_blue,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TILE_W-1:0]    o_tile_index,
    output logic [DIST_W-1:0]    o_best_distance
);

    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int HALF_W = DW - 1;
    localparam int NPX_W  = 2 * HALF_W;
    localparam int CW     = ((DW > POS_W) ? DW : POS_W) + 2;
    localparam int T_W    = $clog2(TILES_PER_SIDE);
    localparam int CH_W   = $clog2(CHANNELS);
    localparam int K_W    = $clog2(NENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_ACC, S_FIN_START, S_FIN_WAIT, S_CLS, S_EMIT
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_width;
    logic [CFG_W-1:0]    r_height;
    logic [CMD_W-1:0]    r_cmd;
    logic [POS_W-1:0]    r_pos_x;
    logic [POS_W-1:0]    r_pos_y;
    logic [COLOR_W-1:0]  r_col [CHANNELS];
    logic [SUM_W-1:0]    r_sums [NENTRIES];
    logic [AVG_W-1:0]    r_avg [NTILES][CHANNELS];
    logic [TILES_PER_SIDE-1:0] r_mask_x;
    logic [TILES_PER_SIDE-1:0] r_mask_y;
    logic [NPX_W-1:0]    r_npx;
    logic [T_W-1:0]      r_tx;
    logic [T_W-1:0]      r_ty;
    logic [CH_W-1:0]     r_ch;
    logic [K_W-1:0]      r_k;
    logic [DIST_W-1:0]   r_record;
    logic [TILE_W-1:0]   r_winner;
    logic                r_out_valid;
    logic [TILE_W-1:0]   r_out_tile;
    logic [DIST_W-1:0]   r_out_dist;

    logic [DW-1:0]       w_dim;
    logic [DW-1:0]       h_dim;
    logic [TILES_PER_SIDE-1:0] mask_x;
    logic [TILES_PER_SIDE-1:0] mask_y;
    logic [NPX_W-1:0]    npx;
    logic [TILE_W-1:0]   tile_idx;
    logic                covered;
    logic [SUM_W:0]      acc_sum;
    logic [SUM_W-1:0]    acc_sat;
    logic [DIST_W-1:0]   cls_dist;
    logic                last_ch;
    logic                last_tx;
    logic                last_ty;
    logic                div_start;
    logic                div_done;
    logic [AVG_W-1:0]    div_quot;
    logic                out_free;

    // Frame dimensions are used clamped, so a tile always holds at least one pixel.
    always_comb begin
        if (r_width < CFG_W'(DIM_MIN)) begin
            w_dim = DW'(DIM_MIN);
        end else if (int'(r_width) > MAX_DIM) begin
            w_dim = DW'(MAX_DIM);
        end else begin
            w_dim = DW'(r_width);
        end
        if (r_height < CFG_W'(DIM_MIN)) begin
            h_dim = DW'(DIM_MIN);
        end else if (int'(r_height) > MAX_DIM) begin
            h_dim = DW'(MAX_DIM);
        end else begin
            h_dim = DW'(r_height);
        end
    end

    // Tile t spans [t*dim/4, t*dim/4 + dim/2) on each axis. A pixel beyond the
    // frame falls outside every tile, so it needs no test of its own.
    always_comb begin
        logic [CW-1:0] start_x;
        logic [CW-1:0] start_y;
        logic [CW-1:0] half_x;
        logic [CW-1:0] half_y;
        half_x = CW'(w_dim >> 1);
        half_y = CW'(h_dim >> 1);
        for (int t = 0; t < TILES_PER_SIDE; t++) begin
            start_x   = (CW'(t) * CW'(w_dim)) >> 2;
            start_y   = (CW'(t) * CW'(h_dim)) >> 2;
            mask_x[t] = (CW'(r_pos_x) >= start_x) && (CW'(r_pos_x) < start_x + half_x);
            mask_y[t] = (CW'(r_pos_y) >= start_y) && (CW'(r_pos_y) < start_y + half_y);
        end
    end

    assign npx = NPX_W'(HALF_W'(w_dim >> 1)) * NPX_W'(HALF_W'(h_dim >> 1));

    assign tile_idx = TILE_W'(r_ty) * TILE_W'(TILES_PER_SIDE) + TILE_W'(r_tx);
    assign covered  = r_mask_x[r_tx] & r_mask_y[r_ty];
    assign acc_sum  = {1'b0, r_sums[r_k]} + (SUM_W + 1)'(r_col[r_ch]);
    assign acc_sat  = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

    always_comb begin
        logic [COLOR_W-1:0] a;
        logic [COLOR_W-1:0] c;
        cls_dist = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            a = r_avg[tile_idx][ch];
            c = r_col[ch];
            cls_dist = cls_dist + DIST_W'((c > a) ? c - a : a - c);
        end
    end

    assign last_ch   = r_ch == CH_W'(CHANNELS - 1);
    assign last_tx   = r_tx == T_W'(TILES_PER_SIDE - 1);
    assign last_ty   = r_ty == T_W'(TILES_PER_SIDE - 1);
    assign div_start = r_state == S_FIN_START;
    assign out_free  = !r_out_valid || !i_out_stall;

    tanc_div #(
        .DIV_W (NPX_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sums[r_k]),
        .i_divisor  (r_npx),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_cmd       <= CMD_ACCUM;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_mask_x    <= '0;
            r_mask_y    <= '0;
            r_npx       <= '0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_ch        <= '0;
            r_k         <= '0;
            r_record    <= '0;
            r_winner    <= '0;
            r_out_valid <= 1'b0;
            r_out_tile  <= '0;
            r_out_dist  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_col[i] <= '0;
            end
            for (int i = 0; i < NENTRIES; i++) begin
                r_sums[i] <= '0;
            end
            for (int t = 0; t < NTILES; t++) begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    r_avg[t][ch] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_width  <= r_width;
                endcase
            end

            // In the post state a drained register is refilled below instead.
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_command;
                        r_pos_x  <= i_pos_x;
                        r_pos_y  <= i_pos_y;
                        r_col[0] <= i_red;
                        r_col[1] <= i_green;
                        r_col[2] <= i_blue;
                        r_tx     <= '0;
                        r_ty     <= '0;
                        r_ch     <= '0;
                        r_k      <= '0;
                        r_record <= DIST_W'(NO_RECORD);
                        r_winner <= '0;
                        r_state  <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_mask_x <= mask_x;
                    r_mask_y <= mask_y;
                    r_npx    <= npx;
                    unique case (r_cmd)
                        CMD_ACCUM:    r_state <= S_ACC;
                        CMD_FINISH:   r_state <= S_FIN_START;
                        CMD_CLASSIFY: r_state <= S_CLS;
                        default:      r_state <= S_IDLE;
                    endcase
                end
                S_ACC, S_FIN_WAIT: begin
                    if (r_state == S_ACC || div_done) begin
                        if (r_state == S_ACC) begin
                            if (covered) begin
                                r_sums[r_k] <= acc_sat;
                            end
                        end else begin
                            r_avg[tile_idx][r_ch] <= div_quot;
                            r_sums[r_k]           <= '0;
                        end
                        r_k <= r_k + K_W'(1);
                        if (!last_ch) begin
                            r_ch <= r_ch + CH_W'(1);
                        end else begin
                            r_ch <= '0;
                            if (!last_tx) begin
                                r_tx <= r_tx + T_W'(1);
                            end else begin
                                r_tx <= '0;
                                r_ty <= r_ty + T_W'(1);
                            end
                        end
                        if (last_ch && last_tx && last_ty) begin
                            r_state <= S_IDLE;
                        end else if (r_state == S_FIN_WAIT) begin
                            r_state <= S_FIN_START;
                        end
                    end
                end
                S_FIN_START: begin
                    r_state <= S_FIN_WAIT;
                end
                S_CLS: begin
                    // Strict compare keeps the lowest tile index on a tie.
                    if (cls_dist < r_record) begin
                        r_record <= cls_dist;
                        r_winner <= tile_idx;
                    end
                    if (!last_tx) begin
                        r_tx <= r_tx + T_W'(1);
                    end else begin
                        r_tx <= '0;
                        r_ty <= r_ty + T_W'(1);
                    end
                    if (last_tx && last_ty) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_tile  <= r_winner;
                        r_out_dist  <= r_record;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_tile_index    = r_out_tile;
    assign o_best_distance = r_out_dist;

endmodule

/* design/tanc_div.sv */
// Iterative divider that turns a tile sum into an 8-bit average, saturating at 255.
// Depends on tanc_pkg for the sum and average widths.
module tanc_div import tanc_pkg::*; #(
    parameter int DIV_W = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SUM_W-1:0]   i_dividend,
    input  logic [DIV_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [AVG_W-1:0]   o_quot
);

    localparam int HI_W  = SUM_W - AVG_W;
    localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;
    localparam int CNT_W = $clog2(AVG_W);

    typedef enum logic {D_IDLE, D_RUN} t_dstate;

    t_dstate            r_state;
    logic [DIV_W-1:0]   r_rem;
    logic [AVG_W-1:0]   r_low;
    logic [AVG_W-1:0]   r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    logic [HI_W-1:0]    hi;
    logic               saturate;
    logic [DIV_W:0]     trial;
    logic               fits;

    // The upper bits of the sum are compared first: if they reach the divisor,
    // the quotient needs more than eight bits and is clipped.
    assign hi       = i_dividend[SUM_W-1:AVG_W];
    assign saturate = CMP_W'(hi) >= CMP_W'(i_divisor);
    assign trial    = {r_rem, r_low[AVG_W-1]};
    assign fits     = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_rem   <= '0;
            r_low   <= '0;
            r_quot  <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        if (saturate) begin
                            r_quot <= '1;
                            r_done <= 1'b1;
                        end else begin
                            r_rem   <= DIV_W'(hi);
                            r_low   <= i_dividend[AVG_W-1:0];
                            r_quot  <= '0;
                            r_cnt   <= '0;
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    if (fits) begin
                        r_rem <= DIV_W'(trial - {1'b0, i_divisor});
                    end else begin
                        r_rem <= trial[DIV_W-1:0];
                    end
                    r_quot <= {r_quot[AVG_W-2:0], fits};
                    r_low  <= {r_low[AVG_W-2:0], 1'b0};
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(AVG_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/tanc_checker.sv */
// Port-level checker for the tile-average nearest color matcher, bound to the top level.
// Depends on tanc_pkg and the assertion macros in the defines header.
`include "tile_average_nearest_color_match_defines.svh"

module tanc_checker import tanc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [CMD_W-1:0]     i_command,
    input logic [POS_W-1:0]     i_pos_x,
    input logic [POS_W-1:0]     i_pos_y,
    input logic [COLOR_W-1:0]   i_red,
    input logic [COLOR_W-1:0]   i_green,
    input logic [COLOR_W-1:0]   i_blue,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [TILE_W-1:0]    o_tile_index,
    input logic [DIST_W-1:0]    o_best_distance
);

    // Every command, the unused one too, stalls the input in the cycle after it is accepted.
    `TANC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after a transaction")

    `TANC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_tile_index) && $stable(o_best_distance), "stalled result changed")

    `TANC_ASSERT_IMPL(a_tile_range, i_clk, i_rst_n, o_out_valid, o_tile_index < TILE_W'(NTILES), "winning tile out of range")

    `TANC_ASSERT_IMPL(a_dist_range, i_clk, i_rst_n, o_out_valid, o_best_distance <= DIST_W'(MAX_DIST), "distance above the largest L1 value")

endmodule

bind tile_average_nearest_color_match tanc_checker u_tanc_checker (.*);

/* tb/tile_match_checker.sv */
`timescale 1ns / 1ps
// Checker for the tile-average nearest color matcher: watches the register, pixel and
// match channels, predicts each classify result and compares it. Depends on tanc_pkg.
module tile_match_checker import tanc_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [COLOR_W-1:0]   i_red,
    input  logic [COLOR_W-1:0]   i_green,
    input  logic [COLOR_W-1:0]   i_blue,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [TILE_W-1:0]    i_tile_index,
    input  logic [DIST_W-1:0]    i_best_distance,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int QUARTER     = 4;
    localparam int SUM_MAX     = (1 << SUM_W) - 1;
    localparam int AVG_MAX     = (1 << AVG_W) - 1;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic [DIST_W-1:0] distance;
    } t_match;

    t_match           expected_matches [$];
    logic [SUM_W-1:0] tile_sum [NENTRIES];
    logic [AVG_W-1:0] tile_avg [NENTRIES];
    logic [CFG_W-1:0] frame_w_reg;
    logic [CFG_W-1:0] frame_h_reg;

    function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
        if (raw < DIM_MIN) return DIM_MIN;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic bit covers(input int t, input int p, input int dim);
        int start;
        start = t * dim / QUARTER;
        return (p >= start) && (p < start + dim / 2);
    endfunction

    function automatic void add_pixel(input int px, input int py,
                                      input int r, input int g, input int b);
        int w;
        int h;
        int k;
        int s;
        int col [CHANNELS];
        w = clamp_dim(frame_w_reg);
        h = clamp_dim(frame_h_reg);
        col[0] = r;
        col[1] = g;
        col[2] = b;
        if (px >= w || py >= h) return;
        for (int ty = 0; ty < TILES_PER_SIDE; ty++) begin
            for (int tx = 0; tx < TILES_PER_SIDE; tx++) begin
                if (covers(ty, py, h) && covers(tx, px, w)) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        k = (ty * TILES_PER_SIDE + tx) * CHANNELS + c;
                        s = int'(tile_sum[k]) + col[c];
                        tile_sum[k] = (s > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(s);
                    end
                end
            end
        end
    endfunction

    function automatic void finish_frame();
        int npx;
        int a;
        npx = (clamp_dim(frame_w_reg) / 2) * (clamp_dim(frame_h_reg) / 2);
        for (int i = 0; i < NENTRIES; i++) begin
            a = int'(tile_sum[i]) / npx;
            tile_avg[i] = (a > AVG_MAX) ? AVG_W'(AVG_MAX) : AVG_W'(a);
            tile_sum[i] = '0;
        end
    endfunction

    function automatic t_match nearest_tile(input int r, input int g, input int b);
        int record;
        int winner;
        int d;
        int diff;
        int col [CHANNELS];
        t_match m;
        col[0] = r;
        col[1] = g;
        col[2] = b;
        record = NO_RECORD;
        winner = 0;
        for (int i = 0; i < NTILES; i++) begin
            d = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                diff = col[c] - int'(tile_avg[i * CHANNELS + c]);
                d += (diff < 0) ? -diff : diff;
            end
            // Strictly less, so an equal distance keeps the lower tile.
            if (d < record) begin
                record = d;
                winner = i;
            end
        end
        m.tile = TILE_W'(winner);
        m.distance = DIST_W'(record);
        return m;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_match want;
        if (!i_rst_n) begin
            frame_w_reg = WIDTH_RST;
            frame_h_reg = HEIGHT_RST;
            for (int i = 0; i < NENTRIES; i++) begin
                tile_sum[i] = '0;
                tile_avg[i] = '0;
            end
            expected_matches.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_matches.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display("%0t: result with no classify pending: tile %0d distance %0d",
                                 $time, i_tile_index, i_best_distance);
                end else begin
                    want = expected_matches.pop_front();
                    if (i_tile_index !== want.tile || i_best_distance !== want.distance) begin
                        o_errors++;
                        if (o_errors <= MAX_REPORTS)
                            $display("%0t: expected tile %0d dist %0d, got tile %0d dist %0d",
                                     $time, want.tile, want.distance,
                                     i_tile_index, i_best_distance);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:  frame_w_reg = i_cfg_data;
                    CFG_HEIGHT: frame_h_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    CMD_ACCUM:    add_pixel(i_pos_x, i_pos_y, i_red, i_green, i_blue);
                    CMD_FINISH:   finish_frame();
                    CMD_CLASSIFY: expected_matches.insert(expected_matches.size(),
                                      nearest_tile(i_red, i_green, i_blue));
                    default: ;
                endcase
            end
        end
        o_pending = expected_matches.size();
    end

endmodule

/* tb/tile_average_nearest_color_match_tb.sv */
`timescale 1ns / 1ps
// Top of the tile-average color matcher testbench: clock, reset, frame and classify
// stimulus, receiver pacing, watchdog and verdict. Depends on tanc_pkg and tile_match_checker.
module tile_average_nearest_color_match_tb;
    import tanc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int SETTLE_CYCLES  = 320;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_PHASE = 1;
    localparam int SAT_PHASE      = 3;
    localparam int SAT_REPEATS    = 1070;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_command;
    logic [POS_W-1:0]     i_pos_x;
    logic [POS_W-1:0]     i_pos_y;
    logic [COLOR_W-1:0]   i_red;
    logic [COLOR_W-1:0]   i_green;
    logic [COLOR_W-1:0]   i_blue;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [TILE_W-1:0]    o_tile_index;
    logic [DIST_W-1:0]    o_best_distance;

    int mismatch_count;
    int pending_matches;
    int items_sent;
    int hold_requests;
    int holds_done;
    int idle_cycles = 0;
    bit no_gaps;
    int palette [4][CHANNELS];

    always #CLK_HALF i_clk = ~i_clk;

    tile_average_nearest_color_match i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tile_index    (o_tile_index),
        .o_best_distance (o_best_distance)
    );

    tile_match_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_tile_index    (o_tile_index),
        .i_best_distance (o_best_distance),
        .o_errors        (mismatch_count),
        .o_pending       (pending_matches)
    );

    // Mostly short idle stretches with an occasional long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 6);
        if (r < 95) return $urandom_range(7, 40);
        return $urandom_range(100, 300);
    endfunction

    function automatic int eff_dim(input int raw);
        return (raw < DIM_MIN) ? DIM_MIN : (raw > MAX_DIM_DEF) ? MAX_DIM_DEF : raw;
    endfunction

    function automatic int shade(input int base);
        int v;
        v = base + $urandom_range(0, 40) - 20;
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    function automatic void new_palette();
        for (int q = 0; q < 4; q++)
            for (int c = 0; c < CHANNELS; c++)
                palette[q][c] = $urandom_range(0, 255);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is accepted.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int x, input int y,
                             input int r, input int g, input int b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command  <= cmd;
        i_pos_x    <= POS_W'(x);
        i_pos_y    <= POS_W'(y);
        i_red      <= COLOR_W'(r);
        i_green    <= COLOR_W'(g);
        i_blue     <= COLOR_W'(b);
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_any();
        send_item(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(data);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // A finish can still be running after the last result, so allow its full latency.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_matches != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_frame(input int raw_w, input int raw_h);
        settle();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_WIDTH, raw_w);
            write_reg(CFG_HEIGHT, raw_h);
        end else begin
            write_reg(CFG_HEIGHT, raw_h);
            write_reg(CFG_WIDTH, raw_w);
        end
    endtask

    // Occasional junk between frame pixels: unused command, off-frame pixel, repeat pixel.
    task automatic stray_item(input int x, input int y, input int fw, input int fh);
        case ($urandom_range(0, 2))
            0: send_item(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
            1: begin
                if (fw < MAX_DIM_DEF)
                    send_item(CMD_ACCUM, $urandom_range(fw, 63), $urandom_range(0, 63),
                              $urandom_range(0, 255), $urandom_range(0, 255), 255);
                else if (fh < MAX_DIM_DEF)
                    send_item(CMD_ACCUM, $urandom_range(0, 63), $urandom_range(fh, 63),
                              255, $urandom_range(0, 255), $urandom_range(0, 255));
                else
                    send_item(CMD_UNUSED, x, y, 0, 0, 0);
            end
            default: send_item(CMD_ACCUM, x, y, $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
        endcase
    endtask

    task automatic send_frame_pixel(input int x, input int y, input int fw, input int fh);
        int q;
        q = (x * 2 / fw) * 2 + (y * 2 / fh);
        send_item(CMD_ACCUM, x, y, shade(palette[q][0]), shade(palette[q][1]),
                  shade(palette[q][2]));
        if ($urandom_range(0, 99) < 8) stray_item(x, y, fw, fh);
    endtask

    task automatic frame_pass(input int fw, input int fh);
        if (fw * fh <= 100) begin
            for (int y = 0; y < fh; y++)
                for (int x = 0; x < fw; x++)
                    send_frame_pixel(x, y, fw, fh);
        end else begin
            repeat ($urandom_range(30, 80))
                send_frame_pixel($urandom_range(0, fw - 1), $urandom_range(0, fh - 1), fw, fh);
        end
    endtask

    task automatic classify_batch(input int n);
        int q;
        repeat (n) begin
            q = $urandom_range(0, 3);
            if ($urandom_range(0, 1))
                send_item(CMD_CLASSIFY, $urandom_range(0, 63), $urandom_range(0, 63),
                          shade(palette[q][0]), shade(palette[q][1]), shade(palette[q][2]));
            else
                send_item(CMD_CLASSIFY, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tile_average_nearest_color_match_tb: done, errors");
            $finish;
        end
    end

    // Receiver pacing: alternating stall and run stretches, with a long hold on request.
    initial begin : receiver_pacing
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        holds_done = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && run_left == 0) begin
                if (holds_done != hold_requests) begin
                    stall_left = HOLD_CYCLES;
                    holds_done = hold_requests;
                end else begin
                    stall_left = pick_gap();
                end
                run_left = pick_run();
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                run_left--;
            end
        end
    end

    initial begin : stimulus
        int raw_w;
        int raw_h;
        int fw;
        int fh;
        int phase;
        int r;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_ACCUM;
        i_pos_x = '0;
        i_pos_y = '0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        no_gaps = 1'b0;
        hold_requests = 0;
        items_sent = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Classify against the reset averages; position must not matter.
        send_item(CMD_CLASSIFY, 63, 63, 0, 0, 0);
        send_item(CMD_CLASSIFY, 0, 0, 255, 255, 255);
        send_item(CMD_UNUSED, 63, 63, 255, 255, 255);
        // Off-frame pixels for the reset frame size, then two opposite corners and the middle.
        send_item(CMD_ACCUM, 63, 63, 255, 255, 255);
        send_item(CMD_ACCUM, 36, 0, 255, 255, 255);
        send_item(CMD_ACCUM, 0, 32, 255, 255, 255);
        send_item(CMD_ACCUM, 0, 0, 255, 0, 255);
        send_item(CMD_ACCUM, 35, 31, 0, 255, 0);
        send_item(CMD_ACCUM, 18, 16, 128, 64, 32);
        send_item(CMD_FINISH, 0, 0, 0, 0, 0);
        send_item(CMD_CLASSIFY, 0, 0, 255, 0, 255);
        send_item(CMD_CLASSIFY, 21, 42, 0, 255, 0);
        send_item(CMD_CLASSIFY, 42, 21, 0, 0, 0);
        // Smallest frame: one pixel per tile, so a doubled pixel clips its average.
        set_frame(DIM_MIN, DIM_MIN);
        send_item(CMD_ACCUM, 0, 0, 255, 255, 255);
        send_item(CMD_ACCUM, 0, 0, 255, 255, 255);
        send_item(CMD_ACCUM, 1, 1, 0, 128, 255);
        send_item(CMD_FINISH, 63, 63, 255, 255, 255);
        send_item(CMD_CLASSIFY, 1, 1, 255, 255, 255);
        send_item(CMD_CLASSIFY, 0, 0, 0, 128, 255);
        send_item(CMD_CLASSIFY, 0, 0, 10, 20, 30);

        items_sent = 0;
        for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
            case (phase)
                0: begin raw_w = 64;  raw_h = 64;  end
                1: begin raw_w = 0;   raw_h = 127; end
                2: begin raw_w = 2;   raw_h = 64;  end
                3: begin raw_w = 2;   raw_h = 2;   end
                4: begin raw_w = 64;  raw_h = 2;   end
                5: begin raw_w = 127; raw_h = 1;   end
                default: begin
                    r = $urandom_range(0, 19);
                    if (r < 14) begin
                        raw_w = $urandom_range(2, 10);
                        raw_h = $urandom_range(2, 10);
                    end else if (r < 18) begin
                        raw_w = $urandom_range(0, 127);
                        raw_h = $urandom_range(0, 127);
                    end else begin
                        raw_w = $urandom_range(40, 64);
                        raw_h = $urandom_range(40, 64);
                    end
                end
            endcase
            set_frame(raw_w, raw_h);
            fw = eff_dim(raw_w);
            fh = eff_dim(raw_h);
            new_palette();
            no_gaps = ($urandom_range(0, 3) == 0);

            if (phase == SAT_PHASE) begin
                // Same pixel over and over until its tile sums clip.
                repeat (SAT_REPEATS)
                    send_item(CMD_ACCUM, 1, 1, $urandom_range(250, 255),
                              $urandom_range(250, 255), $urandom_range(250, 255));
            end else if ($urandom_range(0, 4) == 0) begin
                repeat (15) send_any();
            end else begin
                frame_pass(fw, fh);
            end

            // Sometimes skip the finish so classify sees stale averages.
            if (phase == SAT_PHASE || $urandom_range(0, 99) < 85)
                send_item(CMD_FINISH, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));

            if (phase == PRESSURE_PHASE) begin
                // Nothing is offered while waiting for the receiver to start its hold.
                i_in_valid <= 1'b0;
                hold_requests++;
                while (holds_done != hold_requests) @(negedge i_clk);
                no_gaps = 1'b1;
                classify_batch(12);
            end else begin
                classify_batch($urandom_range(3, 10));
            end
        end

        settle();
        if (mismatch_count == 0 && pending_matches == 0)
            $display("tile_average_nearest_color_match_tb: done, clean");
        else
            $display("tile_average_nearest_color_match_tb: done, errors");
        $finish;
    end

endmodule
